// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RRW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrw assertion failed");

// next-cycle implication, checked out of reset
`define RRW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrw assertion failed");

`endif

// ===== src/rrw_pkg.sv =====
// package: codes, widths and types of the robust residual weighting block
`default_nettype none
package rrw_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    // weight kind codes
    localparam logic [1:0] KIND_UNIT    = 2'd0;
    localparam logic [1:0] KIND_STUDENT = 2'd1;
    localparam logic [1:0] KIND_TUKEY   = 2'd2;
    localparam logic [1:0] KIND_HUBER   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TUKEY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUBER = 3'd4;

    // per-item flags carried past the second divider
    typedef struct packed {
        logic force_one;
        logic force_zero;
        logic is_tukey;
    } side_t;

endpackage
`default_nettype wire

// ===== src/rrw_ifs.sv =====
// item channel interfaces: residual in, weight out
`default_nettype none
interface rrw_resid_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] residual;
    logic               residual_finite;
    modport source (output valid, residual, residual_finite, input ready);
    modport sink (input valid, residual, residual_finite, output ready);
endinterface

interface rrw_wgt_if #(parameter int WEIGHT_W = 17);
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    modport source (output valid, weight, input ready);
    modport sink (input valid, weight, output ready);
endinterface
`default_nettype wire

// ===== src/rrw_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module rrw_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         q,
    output logic                   sat,
    output logic [SIDE_W-1:0]      side_out
);
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              valid_reg [0:Q_W];
    logic [DEN_W-1:0]  rem_reg   [0:Q_W];
    logic [Q_W-1:0]    lo_reg    [0:Q_W];
    logic [Q_W-1:0]    quo_reg   [0:Q_W];
    logic [DEN_W-1:0]  den_reg   [0:Q_W];
    logic              sat_reg   [0:Q_W];
    logic [SIDE_W-1:0] side_reg  [0:Q_W];

    logic [HI_W-1:0] num_hi;
    logic            sat_next;

    assign num_hi   = num[NUM_W-1:Q_W];
    // quotient does not fit in Q_W bits
    assign sat_next = CMP_W'(num_hi) >= CMP_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num_hi);
            lo_reg[0]   <= num[Q_W-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            sat_reg[0]  <= sat_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           qbit;
        logic [DEN_W-1:0] rem_next;

        assign trial    = {rem_reg[k-1], lo_reg[k-1][Q_W-1]};
        assign diff     = trial - {1'b0, den_reg[k-1]};
        assign qbit     = ~diff[DEN_W];
        assign rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                lo_reg[k]   <= {lo_reg[k-1][Q_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][Q_W-2:0], qbit};
                den_reg[k]  <= den_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign q         = quo_reg[Q_W];
    assign sat       = sat_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule
`default_nettype wire

// ===== src/rrw_tail.sv =====
// weight shaping after the second divide: clamp, tukey polynomial, final select
`default_nettype none
module rrw_tail #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [FRAC_BITS:0] q,
    input  wire logic             sat,
    input  wire rrw_pkg::side_t   side,
    output logic                  out_valid,
    output logic [FRAC_BITS:0]    weight
);
    import rrw_pkg::*;

    localparam int W_W  = FRAC_BITS + 1;
    localparam int SQ_W = 2 * W_W;
    localparam logic [W_W-1:0] ONE = W_W'(2 ** FRAC_BITS);

    logic [W_W-1:0]  c1_reg, c2_reg, c3_reg, c4_reg;
    logic [SQ_W-1:0] qq_reg, tt_reg;
    logic [W_W-1:0]  t_reg;
    side_t           s1_reg, s2_reg, s3_reg, s4_reg;
    logic [4:0]      valid_reg;
    logic [W_W-1:0]  weight_reg;

    logic [W_W-1:0]  c_next;
    logic [SQ_W-FRAC_BITS-1:0] r_full;
    logic [W_W-1:0]  r_next;
    logic [W_W-1:0]  w_next;

    assign c_next = (sat || q > ONE) ? ONE : q;

    // r = q*q >> frac, held at one
    assign r_full = qq_reg[SQ_W-1:FRAC_BITS];
    assign r_next = (r_full > (SQ_W-FRAC_BITS)'(ONE)) ? ONE : W_W'(r_full);

    always_comb
    begin
        if (s4_reg.force_zero)
        begin
            w_next = '0;
        end
        else if (s4_reg.force_one)
        begin
            w_next = ONE;
        end
        else if (s4_reg.is_tukey)
        begin
            w_next = tt_reg[FRAC_BITS+W_W-1:FRAC_BITS];
        end
        else
        begin
            w_next = c4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= c_next;
            s1_reg     <= side;
            qq_reg     <= SQ_W'(c1_reg) * SQ_W'(c1_reg);
            c2_reg     <= c1_reg;
            s2_reg     <= s1_reg;
            t_reg      <= ONE - r_next;
            c3_reg     <= c2_reg;
            s3_reg     <= s2_reg;
            tt_reg     <= SQ_W'(t_reg) * SQ_W'(t_reg);
            c4_reg     <= c3_reg;
            s4_reg     <= s3_reg;
            weight_reg <= w_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign weight    = weight_reg;

endmodule
`default_nettype wire

// ===== src/robust_residual_weighting_top.sv =====
// top level: robust residual weighting, one residual in, one weight out
`default_nettype none
// Takes one residual per item and returns its robust weight (unit, student-t,
// tukey biweight or huber, picked by the kind register). One item enters per
// clock cycle unless a finished weight is waiting and not taken. The pipeline
// is two bit-per-stage dividers (input register plus 32 stages for
// residual/scale, input register plus FRAC_BITS+1 stages for the weight
// quotient) plus one square stage and five shaping stages. While a weight
// waits untaken the whole pipeline holds. Configuration writes belong to idle
// periods: registers are read live by the stages.
module robust_residual_weighting_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    rrw_resid_if.sink                      resid,
    rrw_wgt_if.source                      wgt,
    input  wire logic                      cfg_we,
    input  wire logic [rrw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rrw_pkg::DATA_W-1:0]    cfg_data
);
    import rrw_pkg::*;

    `include "assert_macros.svh"

    localparam int W_W    = FRAC_BITS + 1;
    localparam int NUM1_W = DATA_W + FRAC_BITS;
    localparam int DEN2_W = DATA_W + 1;
    localparam int NUM2_W = DEN2_W + FRAC_BITS;
    localparam int PROD_W = 2 * DATA_W;
    localparam logic [DATA_W-1:0] ONE_D     = DATA_W'(2 ** FRAC_BITS);
    localparam logic [DATA_W-1:0] SCALE_MIN = DATA_W'((2 ** FRAC_BITS + 999) / 1000);
    localparam logic [W_W-1:0]    ONE_W     = W_W'(2 ** FRAC_BITS);

    // configuration registers
    logic [1:0]        kind_reg;
    logic [DATA_W-1:0] scale_reg, tukey_reg, dof_reg, huber_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_STUDENT;
            scale_reg <= 32'd65536;
            tukey_reg <= 32'd307044;
            dof_reg   <= 32'd327680;
            huber_reg <= 32'd88146;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KIND:  kind_reg  <= cfg_data[1:0];
                CFG_SCALE: scale_reg <= cfg_data;
                CFG_TUKEY: tukey_reg <= cfg_data;
                CFG_DOF:   dof_reg   <= cfg_data;
                CFG_HUBER: huber_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // global pipeline advance
    logic en;
    logic tail_valid;
    logic [W_W-1:0] tail_weight;

    assign en          = !tail_valid || wgt.ready;
    assign resid.ready = en;
    assign wgt.valid   = tail_valid;
    assign wgt.weight  = tail_weight;

    // first divide: a = |residual| << frac / scale
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] scale_eff;
    logic              d1_valid, d1_sat;
    logic [DATA_W-1:0] d1_q;
    logic [0:0]        d1_side;

    assign mag       = resid.residual[DATA_W-1] ? DATA_W'(-resid.residual)
                                                : DATA_W'(resid.residual);
    assign scale_eff = (scale_reg < SCALE_MIN) ? SCALE_MIN : scale_reg;

    rrw_div #(
        .NUM_W  (NUM1_W),
        .DEN_W  (DATA_W),
        .Q_W    (DATA_W),
        .SIDE_W (1)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (resid.valid),
        .num       ({mag, FRAC_BITS'(0)}),
        .den       (scale_eff),
        .side_in   (resid.residual_finite),
        .out_valid (d1_valid),
        .q         (d1_q),
        .sat       (d1_sat),
        .side_out  (d1_side)
    );

    // square stage with comparisons against the thresholds
    logic [DATA_W-1:0] a_val;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_a_reg;
    logic [PROD_W-1:0] m_prod_reg;
    logic              m_finite_reg, m_agtb_reg, m_altk_reg, m_azero_reg;

    assign a_val = d1_sat ? '1 : d1_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_a_reg      <= a_val;
            m_prod_reg   <= PROD_W'(a_val) * PROD_W'(a_val);
            m_finite_reg <= d1_side[0];
            m_agtb_reg   <= a_val > tukey_reg;
            m_altk_reg   <= a_val < huber_reg;
            m_azero_reg  <= a_val == '0;
        end
    end

    // operand select for the weight divide
    logic [DATA_W-1:0] x2;
    logic [DEN2_W-1:0] den_st;
    logic [NUM2_W-1:0] num2;
    logic [DEN2_W-1:0] den2;
    side_t             side2;

    assign x2     = (|m_prod_reg[PROD_W-1:DATA_W+FRAC_BITS]) ? '1
                  : m_prod_reg[DATA_W+FRAC_BITS-1:FRAC_BITS];
    assign den_st = DEN2_W'(dof_reg) + DEN2_W'(x2);

    always_comb
    begin
        side2.force_one  = 1'b0;
        side2.force_zero = !m_finite_reg;
        side2.is_tukey   = 1'b0;
        case (kind_reg)
            KIND_UNIT:
            begin
                num2            = '0;
                den2            = '0;
                side2.force_one = m_finite_reg;
            end
            KIND_STUDENT:
            begin
                num2            = {DEN2_W'(dof_reg) + DEN2_W'(ONE_D), FRAC_BITS'(0)};
                den2            = den_st;
                side2.force_one = m_finite_reg && den_st == '0;
            end
            KIND_TUKEY:
            begin
                num2             = NUM2_W'({m_a_reg, FRAC_BITS'(0)});
                den2             = DEN2_W'(tukey_reg);
                side2.is_tukey   = 1'b1;
                side2.force_zero = !m_finite_reg || tukey_reg == '0 || m_agtb_reg;
            end
            KIND_HUBER:
            begin
                num2            = NUM2_W'({huber_reg, FRAC_BITS'(0)});
                den2            = DEN2_W'(m_a_reg);
                side2.force_one = m_finite_reg && (m_altk_reg || m_azero_reg);
            end
            default:
            begin
                num2 = '0;
                den2 = '0;
            end
        endcase
    end

    // second divide: weight quotient, FRAC_BITS+1 bits plus overflow
    logic           d2_valid, d2_sat;
    logic [W_W-1:0] d2_q;
    logic [$bits(side_t)-1:0] d2_side_bits;
    side_t          d2_side;

    rrw_div #(
        .NUM_W  (NUM2_W),
        .DEN_W  (DEN2_W),
        .Q_W    (W_W),
        .SIDE_W ($bits(side_t))
    ) u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .num       (num2),
        .den       (den2),
        .side_in   (side2),
        .out_valid (d2_valid),
        .q         (d2_q),
        .sat       (d2_sat),
        .side_out  (d2_side_bits)
    );

    assign d2_side = side_t'(d2_side_bits);

    rrw_tail #(
        .FRAC_BITS (FRAC_BITS)
    ) u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .q         (d2_q),
        .sat       (d2_sat),
        .side      (d2_side),
        .out_valid (tail_valid),
        .weight    (tail_weight)
    );

    `RRW_ASSERT_NOW(a_weight_range, tail_valid, tail_weight <= ONE_W)
    `RRW_ASSERT_NOW(a_tukey_no_ovf, d2_valid && d2_side.is_tukey && !d2_side.force_zero, !d2_sat)
    `RRW_ASSERT_NEXT(a_stall_freeze, !en && d1_valid, d1_valid && $stable(d1_q))

endmodule
`default_nettype wire

// ===== tb/rrw_tb_ifs.sv =====
// testbench note: the channel interfaces come from the rtl file rrw_ifs.sv
package rrw_tb_consts;
    localparam int WEIGHT_W = 17;
    localparam int LATENCY  = 16 + 41;
endpackage

// ===== tb/tb.sv =====
// testbench for robust_residual_weighting_top: directed and random residuals checked
module tb;
    import rrw_pkg::*;
    import rrw_tb_consts::*;

    localparam longint ONE = 64'd65536;
    localparam longint SMIN = 64'd66;
    localparam longint SAT = 64'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    rrw_resid_if resid ();
    rrw_wgt_if #(.WEIGHT_W(WEIGHT_W)) wgt ();

    robust_residual_weighting_top dut (
        .clk(clk), .rst_n(rst_n), .resid(resid.sink), .wgt(wgt.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // shadow copy of the registers
    logic [1:0] kind_q;
    longint unsigned scale_q, tukey_q, dof_q, huber_q;

    logic [WEIGHT_W-1:0] weight_queue[$];
    int errors = 0;
    int stall_mode = 0;
    int long_hold = 0;
    int idle_cycles = 0;

    function automatic logic [WEIGHT_W-1:0] robust_weight(logic signed [31:0] r, logic fin);
        longint unsigned mag, s, a, x2, den, w, q, rr, t;
        if (!fin)
            return '0;
        mag = r[31] ? ((~{32'd0, r} + 1) & SAT) : {32'd0, r};
        s = scale_q < SMIN ? SMIN : scale_q;
        a = (mag << 16) / s;
        if (a > SAT)
            a = SAT;
        case (kind_q)
            KIND_UNIT: w = ONE;
            KIND_STUDENT:
            begin
                x2 = (a * a) >> 16;
                if (x2 > SAT)
                    x2 = SAT;
                den = dof_q + x2;
                if (den == 0)
                    w = ONE;
                else
                    w = ((dof_q + ONE) << 16) / den;
                if (w > ONE)
                    w = ONE;
            end
            KIND_TUKEY:
            begin
                if (tukey_q == 0 || a > tukey_q)
                    w = 0;
                else
                begin
                    q = (a << 16) / tukey_q;
                    rr = (q * q) >> 16;
                    if (rr > ONE)
                        rr = ONE;
                    t = ONE - rr;
                    w = (t * t) >> 16;
                end
            end
            default:
            begin
                if (a < huber_q || a == 0)
                    w = ONE;
                else
                begin
                    w = (huber_q << 16) / a;
                    if (w > ONE)
                        w = ONE;
                end
            end
        endcase
        return w[WEIGHT_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KIND: kind_q = val[1:0];
            CFG_SCALE: scale_q = val;
            CFG_TUKEY: tukey_q = val;
            CFG_DOF: dof_q = val;
            CFG_HUBER: huber_q = val;
            default: ;
        endcase
    endtask

    task automatic send_residual(logic signed [31:0] r, logic fin);
        resid.valid <= 1'b1;
        resid.residual <= r;
        resid.residual_finite <= fin;
        @(posedge clk);
        while (!resid.ready)
            @(posedge clk);
        weight_queue.push_back(robust_weight(r, fin));
    endtask

    // drop valid after the last item of a burst
    task automatic idle_gap(int n);
        resid.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        idle_gap(1);
        while (weight_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] random_residual();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 4095);
            2: return -$urandom_range(0, 4095);
            3: return $urandom_range(0, 1 << 20);
            4: return -$urandom_range(0, 1 << 20);
            default: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    task automatic random_items(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < n)
            begin
                send_residual(random_residual(), $urandom_range(0, 15) != 0);
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 8));
        end
    endtask

    task automatic test_directed();
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0001_0000, 32'hFFFF_0000, 32'h0004_AF64};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_KIND, k);
            foreach (edge_vals[i])
                send_residual(edge_vals[i], 1'b1);
            send_residual(32'h1234, 1'b0);
            drain();
        end
    endtask

    task automatic test_special_settings();
        // zero cutoffs and thresholds, scale below the floor, largest settings
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_TUKEY, 0);
        write_reg(CFG_DOF, 0);
        write_reg(CFG_HUBER, 0);
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_KIND, k);
            send_residual(0, 1'b1);
            send_residual(32'h0000_0100, 1'b1);
            send_residual(32'h8000_0000, 1'b1);
            drain();
        end
        write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_TUKEY, 32'hFFFF_FFFF);
        write_reg(CFG_DOF, 32'hFFFF_FFFF);
        write_reg(CFG_HUBER, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_KIND, k);
            send_residual(32'h7FFF_FFFF, 1'b1);
            send_residual(32'h8000_0000, 1'b1);
            send_residual(1, 1'b1);
            drain();
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 12; p++)
        begin
            write_reg(CFG_KIND, $urandom_range(0, 3));
            write_reg(CFG_SCALE, ($urandom_range(0, 1)) ? $urandom_range(1, 1 << 18) : $urandom);
            write_reg(CFG_TUKEY, ($urandom_range(0, 1)) ? $urandom_range(1, 1 << 20) : $urandom);
            write_reg(CFG_DOF, ($urandom_range(0, 1)) ? $urandom_range(1, 1 << 20) : $urandom);
            write_reg(CFG_HUBER, ($urandom_range(0, 1)) ? $urandom_range(1, 1 << 20) : $urandom);
            stall_mode = p % 3;
            random_items(112);
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_KIND, KIND_HUBER);
        long_hold = 300;
        random_items(100);
        drain();
    endtask

    // receiver: stall pattern plus a long hold on request
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            wgt.ready <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else
            case (stall_mode)
                0: wgt.ready <= 1'b1;
                1: wgt.ready <= ($urandom_range(0, 3) != 0);
                default: wgt.ready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    // checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wgt.valid && wgt.ready)
            begin
                if (weight_queue.size() == 0)
                begin
                    $display("%0t unexpected weight: expected none, actual %0d", $time,
                             wgt.weight);
                    errors++;
                end
                else
                begin
                    if (wgt.weight !== weight_queue[0])
                    begin
                        $display("%0t weight mismatch: expected %0d, actual %0d", $time,
                                 weight_queue[0], wgt.weight);
                        errors++;
                    end
                    void'(weight_queue.pop_front());
                end
            end
            if ((wgt.valid && wgt.ready) || (resid.valid && resid.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        resid.valid = 1'b0;
        resid.residual = '0;
        resid.residual_finite = 1'b0;
        wgt.ready = 1'b0;
        kind_q = KIND_STUDENT;
        scale_q = 65536;
        tukey_q = 307044;
        dof_q = 327680;
        huber_q = 88146;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stall_mode = 1;
        random_items(40);
        drain();
        test_directed();
        test_special_settings();
        test_backpressure();
        test_random_settings();
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/rrw_pkg.sv
src/rrw_ifs.sv
src/rrw_div.sv
src/rrw_tail.sv
src/robust_residual_weighting_top.sv
tb/rrw_tb_ifs.sv
tb/tb.sv
